### rtl/wcrms_pkg.sv
// ----------------------------------------------------------------------------
// wcrms_pkg
// shared constants and command/status types for the windowed rms estimator
// ----------------------------------------------------------------------------
package wcrms_pkg;

	localparam int WindowSamples = 32;
	localparam int SlotW         = $clog2(WindowSamples);
	localparam int FillW         = $clog2(WindowSamples + 1);
	localparam int SumW          = 32 + $clog2(WindowSamples);
	localparam int Sqrt2X100     = 141;
	localparam int PctScale      = 100;
	localparam int RmsMax        = 32767;

	// reciprocal of 141/100 scaled by 2^SineShift, rounded up; exact for 15-bit magnitudes
	localparam int     SineShift = 30;
	localparam longint SineMul   =
		((longint'(PctScale) <<< SineShift) + longint'(Sqrt2X100) - 1) / longint'(Sqrt2X100);

	localparam logic CfgRmsMode = 1'b0;
	localparam logic CfgDcOff   = 1'b1;

	typedef struct packed {
		logic load;      // take sample, write window, clear accumulators
		logic scan_rd;   // issue window read at scan index
		logic scan_acc;  // marks the last fold of read data; the datapath folds on rd_ok_q
		logic div_start; // start sum / count (true mode), register sine estimate
		logic sq1_start; // first root
		logic ac_prep;   // register first root for squaring and dc subtraction
		logic sq2_start; // second root
		logic fin;       // register result
	} wcrms_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic div_done;
		logic sq_done;
	} wcrms_sts_t;

endpackage

### rtl/windowed_current_rms_top.sv
// ----------------------------------------------------------------------------
// windowed_current_rms_top
// sliding-window rms estimator for signed current samples
// ----------------------------------------------------------------------------
// channel  direction  handshake            word
// sample   in         sample_valid/stall   sample_ma
// result   out        rms_valid/rms_stall  rms_ma
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// from acceptance to a valid result the word passes the window scan (one
// memory read a cycle), then in true mode only a bit-serial divider for
// sum/count and a square root unit used twice; the sequencer returns to
// idle before the next word is taken
// reset clears fill count, write slot, control and output registers; window memory and accumulators are unreset
// the result sits in an output register; a stalled result holds the sequencer
// ----------------------------------------------------------------------------
module windowed_current_rms_top import wcrms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [15:0] sample_ma,
	output logic               rms_valid,
	input  logic               rms_stall,
	output logic [14:0]        rms_ma,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	wcrms_cmd_t         cmd;
	wcrms_sts_t         sts;
	logic               busy;
	logic               mode_q;
	logic signed [15:0] dc_q;
	logic               out_free;

	// config taken only while the sequencer is idle
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			dc_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CfgRmsMode: mode_q <= cfg_data[0];
				CfgDcOff:   dc_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	// one word in flight; output register drains independently
	assign sample_stall = busy;
	assign out_free     = !rms_valid || !rms_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       rms_valid <= 1'b0;
		else if (cmd.fin)  rms_valid <= 1'b1;
		else if (!rms_stall) rms_valid <= 1'b0;
	end

	wcrms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_go    (sample_valid),
		.mode     (mode_q),
		.sts      (sts),
		.out_free (out_free),
		.cmd      (cmd),
		.busy     (busy)
	);

	wcrms_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (sample_ma),
		.mode   (mode_q),
		.dc_off (dc_q),
		.sts    (sts),
		.result (rms_ma)
	);

endmodule

### rtl/wcrms_ctrl.sv
// ----------------------------------------------------------------------------
// wcrms_ctrl
// sequencer for window scan, divide and two square roots; sine mode skips the divide and roots
// ----------------------------------------------------------------------------
module wcrms_ctrl import wcrms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_go,
	input  logic       mode,
	input  wcrms_sts_t sts,
	input  logic       out_free,
	output wcrms_cmd_t cmd,
	output logic       busy
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SCAN = 9'b000000010,
		ST_LAST = 9'b000000100,
		ST_DIV  = 9'b000001000,
		ST_SQ1  = 9'b000010000,
		ST_AC   = 9'b000100000,
		ST_SQ2  = 9'b001000000,
		ST_FIN  = 9'b010000000,
		ST_WAIT = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (in_go) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) state_d = ST_LAST;
			end
			ST_LAST: begin
				cmd.scan_acc = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_SQ1;
			end
			ST_SQ1: begin
				if (sts.div_done) begin
					if (mode) begin
						cmd.sq1_start = 1'b1;
						state_d       = ST_AC;
					end else begin
						state_d = ST_WAIT;
					end
				end
			end
			ST_AC: begin
				if (sts.sq_done) begin
					cmd.ac_prep = 1'b1;
					state_d     = ST_SQ2;
				end
			end
			ST_SQ2: begin
				cmd.sq2_start = 1'b1;
				state_d       = ST_FIN;
			end
			ST_FIN: begin
				if (sts.sq_done) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

### rtl/wcrms_dp.sv
// ----------------------------------------------------------------------------
// wcrms_dp
// window memory, min/max and square accumulators, divider and root unit
// ----------------------------------------------------------------------------
module wcrms_dp import wcrms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  wcrms_cmd_t         cmd,
	input  logic signed [15:0] sample,
	input  logic               mode,
	input  logic signed [15:0] dc_off,
	output wcrms_sts_t         sts,
	output logic [14:0]        result
);

	logic signed [15:0] mem [WindowSamples];
	logic signed [15:0] rd_q;
	logic [SlotW-1:0]   wslot_q;
	logic [FillW-1:0]   fill_q;
	logic [FillW-1:0]   idx_q;
	logic               rd_ok_q;
	logic signed [15:0] hi_q, lo_q;
	logic [SumW-1:0]    sum_q;
	logic [FillW-1:0]   last_idx;

	// divider: sum of squares by fill count, restoring, one bit a cycle
	logic [SumW-1:0]    num_q, quo_q;
	logic [SumW:0]      rem_q;
	logic [7:0]         den_q;
	logic [6:0]         dcnt_q;
	logic               dbusy_q;
	logic [SumW:0]      rem_sh;

	// root unit: 32-bit floor isqrt, one radicand bit pair per step
	logic [31:0]        sq_n_q, sq_root_q, sq_bit_q;
	logic               sqbusy_q;
	logic [32:0]        sq_trial;

	logic [31:0]        root1_q;
	logic [31:0]        dc2_q;
	logic [31:0]        tot_s1;
	logic [16:0]        p2p;
	logic [45:0]        sine_prod;
	logic [14:0]        sine_q;

	assign last_idx = fill_q - 1'b1;
	assign sts.scan_last = (idx_q == last_idx);
	assign p2p    = 17'({hi_q[15], hi_q} - {lo_q[15], lo_q});
	// half peak-to-peak times 100/141 by reciprocal multiply
	assign sine_prod = 46'(p2p[16:1]) * 46'(SineMul);
	assign rem_sh = {rem_q[SumW-1:0], num_q[SumW-1]};
	assign sq_trial = {1'b0, sq_root_q} + {1'b0, sq_bit_q};
	assign tot_s1 = root1_q * root1_q;

	always_ff @(posedge clk) begin
		if (cmd.load) mem[wslot_q] <= sample;
		rd_q <= mem[idx_q[SlotW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q  <= '0;
			fill_q   <= '0;
			dbusy_q  <= 1'b0;
			sqbusy_q <= 1'b0;
			rd_ok_q  <= 1'b0;
			result   <= '0;
		end else begin
			rd_ok_q <= cmd.scan_rd;
			if (cmd.load) begin
				wslot_q <= (32'(wslot_q) == WindowSamples - 1) ? '0 : wslot_q + 1'b1;
				if (32'(fill_q) < WindowSamples) fill_q <= fill_q + 1'b1;
			end
			if (cmd.div_start && mode) dbusy_q <= 1'b1;
			else if (dbusy_q && dcnt_q == 7'(SumW - 1)) dbusy_q <= 1'b0;
			if (cmd.sq1_start || cmd.sq2_start) sqbusy_q <= 1'b1;
			else if (sqbusy_q && sq_bit_q[1:0] != 2'b00) sqbusy_q <= 1'b0;
			if (cmd.fin) begin
				if (mode) result <= (sq_root_q > 32'(RmsMax)) ? 15'(RmsMax)
					: sq_root_q[14:0];
				else result <= sine_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= '0;
			sum_q <= '0;
			hi_q  <= 16'sh8000;
			lo_q  <= 16'sh7fff;
		end else if (cmd.scan_rd) begin
			idx_q <= idx_q + 1'b1;
		end
		if (rd_ok_q) begin
			if (rd_q > hi_q) hi_q <= rd_q;
			if (rd_q < lo_q) lo_q <= rd_q;
			sum_q <= sum_q + SumW'($unsigned(32'(rd_q * rd_q)));
		end
		if (cmd.div_start) begin
			sine_q <= sine_prod[SineShift +: 15];
			num_q  <= sum_q;
			den_q  <= 8'(fill_q);
			rem_q  <= '0;
			quo_q  <= '0;
			dcnt_q <= '0;
		end else if (dbusy_q) begin
			num_q  <= num_q << 1;
			dcnt_q <= dcnt_q + 1'b1;
			if (rem_sh >= (SumW+1)'(den_q)) begin
				rem_q <= rem_sh - (SumW+1)'(den_q);
				quo_q <= {quo_q[SumW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[SumW-2:0], 1'b0};
			end
		end
		// quotient of sum/count fits in 32 bits (max 2^30)
		if (cmd.sq1_start || cmd.sq2_start) begin
			sq_n_q    <= cmd.sq1_start ? quo_q[31:0]
				: ((tot_s1 > dc2_q) ? tot_s1 - dc2_q : '0);
			sq_root_q <= '0;
			sq_bit_q  <= 32'h4000_0000;
		end else if (sqbusy_q) begin
			if ({1'b0, sq_n_q} >= sq_trial) begin
				sq_n_q    <= sq_n_q - sq_trial[31:0];
				sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
			end else begin
				sq_root_q <= sq_root_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (cmd.ac_prep) root1_q <= sq_root_q;
		dc2_q <= $unsigned(32'(dc_off * dc_off));
	end

	assign sts.div_done = !dbusy_q && !(cmd.div_start && mode);
	assign sts.sq_done  = !sqbusy_q && !cmd.sq1_start && !cmd.sq2_start;

endmodule

### sim/windowed_current_rms_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_current_rms_top_tb
// checks the sliding-window rms estimator against an internal predictor:
// current samples are sent with random gaps, every estimate is compared in
// order with the predicted value, and both estimate modes and a range of dc
// offsets are exercised with the result side stalling at random
// ----------------------------------------------------------------------------
module windowed_current_rms_top_tb;
	import wcrms_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               sample_valid;
	logic               sample_stall;
	logic signed [15:0] sample_ma;
	logic               rms_valid;
	logic               rms_stall;
	logic [14:0]        rms_ma;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [15:0]        cfg_data;

	// predictor state
	logic signed [15:0] win_q [WindowSamples];
	int unsigned        slot_q;
	int unsigned        fill_q;
	logic               mode_q;
	logic signed [15:0] dc_q;

	logic [14:0] rms_expected_q [$];
	int          mismatches;
	int          idle_cycles;
	int          stall_left;    // stall cycles still owed to the current word

	localparam int IdleLimit = 20000;

	windowed_current_rms_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_ma   (sample_ma),
		.rms_valid   (rms_valid),
		.rms_stall   (rms_stall),
		.rms_ma      (rms_ma),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// exact floor square root, bit pair at a time
	function automatic longint unsigned floor_root(longint unsigned n);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n = n - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	// store one sample and work out the estimate it causes
	function automatic logic [14:0] predict_rms(logic signed [15:0] s);
		longint          hi, lo, v, sq_sum, dc2, tot, est;
		longint unsigned r;
		win_q[slot_q] = s;
		slot_q = (slot_q + 1) % WindowSamples;
		if (fill_q < WindowSamples) fill_q++;
		if (!mode_q) begin
			hi = win_q[0];
			lo = win_q[0];
			for (int i = 1; i < fill_q; i++) begin
				v = win_q[i];
				if (v > hi) hi = v;
				if (v < lo) lo = v;
			end
			est = (((hi - lo) >>> 1) * PctScale) / Sqrt2X100;
		end else begin
			sq_sum = 0;
			for (int i = 0; i < fill_q; i++) begin
				v = win_q[i];
				sq_sum += v * v;
			end
			r = floor_root(longint'(sq_sum / fill_q));
			tot = longint'(r * r);
			v = dc_q;
			dc2 = v * v;
			est = (tot > dc2) ? longint'(floor_root(tot - dc2)) : 0;
		end
		if (est > RmsMax) est = RmsMax;
		return est[14:0];
	endfunction

	// send one sample word after a random gap; valid stays up between
	// back-to-back words and drops only when a gap is drawn
	task automatic send_sample(logic signed [15:0] s);
		int gap;
		gap = $urandom_range(0, 8);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_ma    <= s;
		do @(posedge clk); while (sample_stall);
		rms_expected_q.push_back(predict_rms(s));
	endtask

	// register write, only once every estimate has come back
	task automatic write_reg(logic idx, logic [15:0] val);
		sample_valid <= 1'b0;
		while (rms_expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CfgRmsMode) mode_q = val[0];
		else dc_q = val;
	endtask

	// result side: after each word, draw a random stall that runs down only while a word is valid
	always @(posedge clk) begin
		if (rms_valid && !rms_stall) begin
			if (rms_expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected rms word %0d", rms_ma);
			end else begin
				if (rms_ma !== rms_expected_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("rms mismatch: expected %0d actual %0d",
							rms_expected_q[0], rms_ma);
				end
				void'(rms_expected_q.pop_front());
			end
			stall_left = $urandom_range(0, 8);
		end else if (rms_valid && stall_left > 0) begin
			stall_left--;
		end
		if (!arst_n) rms_stall <= 1'b0;
		else rms_stall <= (stall_left > 0);
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (rms_valid && !rms_stall)
				|| (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("windowed_current_rms_top test failed");
			$finish;
		end
	end

	task automatic test_sine_extremes();
		send_sample(16'sd0);
		send_sample(16'sh7fff);
		send_sample(-16'sd32768);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sh5555);
		send_sample(16'shaaaa);
	endtask

	task automatic test_true_extremes();
		write_reg(CfgRmsMode, 16'd1);
		send_sample(-16'sd32768);
		send_sample(-16'sd32768);
		send_sample(16'sh7fff);
		// dc larger than signal clamps to zero
		write_reg(CfgDcOff, 16'h8000);
		send_sample(16'sd100);
		write_reg(CfgDcOff, 16'h7fff);
		send_sample(16'sd5);
		write_reg(CfgDcOff, 16'd10);
		send_sample(16'sd300);
	endtask

	task automatic test_random(int n);
		logic signed [15:0] s;
		for (int p = 0; p < 8; p++) begin
			write_reg(CfgRmsMode, 16'($urandom_range(0, 1)));
			case ($urandom_range(0, 3))
				0: write_reg(CfgDcOff, 16'h8000);
				1: write_reg(CfgDcOff, 16'h7fff);
				2: write_reg(CfgDcOff, 16'd0);
				default: write_reg(CfgDcOff, 16'($urandom_range(0, 16'hffff)));
			endcase
			for (int i = 0; i < n / 8; i++) begin
				case ($urandom_range(0, 4))
					0: s = 16'($urandom_range(0, 16'hffff));
					1: s = $urandom_range(0, 1) ? 16'sh7fff : -16'sd32768;
					2: s = 16'($urandom_range(0, 200)) - 16'sd100;
					default: s = 16'($urandom_range(0, 8000)) - 16'sd4000;
				endcase
				send_sample(s);
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample_ma    = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CfgRmsMode;
		cfg_data     = '0;
		rms_stall    = 1'b0;
		stall_left   = 0;
		mismatches   = 0;
		idle_cycles  = 0;
		slot_q       = 0;
		fill_q       = 0;
		mode_q       = 1'b0;
		dc_q         = '0;
		foreach (win_q[i]) win_q[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sine_extremes();
		test_true_extremes();
		test_random(1336);

		sample_valid <= 1'b0;
		while (rms_expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("windowed_current_rms_top test passed");
		else
			$display("windowed_current_rms_top test failed");
		$finish;
	end

endmodule

### filelist.f
rtl/wcrms_pkg.sv
rtl/wcrms_ctrl.sv
rtl/wcrms_dp.sv
rtl/windowed_current_rms_top.sv
sim/windowed_current_rms_top_tb.sv
